FILE: rtl/smbc_pkg.sv
// Package for the stack-machine bytecode core: command, opcode and fault codes,
// and the packed beat types of the input and result channels.
// No dependencies.
package smbc_pkg;

  localparam logic [1:0] CMD_LOAD    = 2'd0;
  localparam logic [1:0] CMD_STEP    = 2'd1;
  localparam logic [1:0] CMD_RESTART = 2'd2;

  localparam logic [4:0] OP_PUSH    = 5'd0;
  localparam logic [4:0] OP_LOAD    = 5'd1;
  localparam logic [4:0] OP_POP     = 5'd2;
  localparam logic [4:0] OP_MOVI    = 5'd3;
  localparam logic [4:0] OP_ADD     = 5'd4;
  localparam logic [4:0] OP_SUB     = 5'd5;
  localparam logic [4:0] OP_LESS    = 5'd6;
  localparam logic [4:0] OP_EQU     = 5'd7;
  localparam logic [4:0] OP_GRT     = 5'd8;
  localparam logic [4:0] OP_JMP     = 5'd9;
  localparam logic [4:0] OP_JMZ     = 5'd10;
  localparam logic [4:0] OP_CALL    = 5'd11;
  localparam logic [4:0] OP_RET     = 5'd12;
  localparam logic [4:0] OP_PRINTI  = 5'd13;
  localparam logic [4:0] OP_PRINTS  = 5'd14;
  localparam logic [4:0] OP_SCANI   = 5'd15;
  localparam logic [4:0] OP_SCANS   = 5'd16;
  localparam logic [4:0] OP_STOP    = 5'd17;
  localparam logic [4:0] OP_UNKNOWN = 5'd31;

  localparam logic [2:0] FLT_NONE      = 3'd0;
  localparam logic [2:0] FLT_OVERFLOW  = 3'd1;
  localparam logic [2:0] FLT_UNDERFLOW = 3'd2;
  localparam logic [2:0] FLT_CALL_OVF  = 3'd3;
  localparam logic [2:0] FLT_RET_BASE  = 3'd4;
  localparam logic [2:0] FLT_BAD_INDEX = 3'd5;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [11:0]        address;
    logic [31:0]        data;
    logic signed [31:0] scan_value;
  } smbc_in_t;

  typedef struct packed {
    logic [12:0]        pc;
    logic               halted;
    logic               print_valid;
    logic signed [31:0] print_value;
    logic               scan_taken;
    logic [2:0]         fault;
  } smbc_out_t;

endpackage

FILE: rtl/stack_machine_bytecode_core.sv
// Top level of the stack-machine bytecode core: sequencer, program store, data stack
// and frame store. Depends on smbc_pkg and smbc_ram.
//
// Each input beat is one command. A load or restart goes from idle to done; a step
// passes fetch and its operand and stack states, reading the opcode, each inline
// operand and each stack entry in turn from single-port memories with a registered
// read port; the write-back is issued in the state taking the last read. Arithmetic
// runs fetch, top, second; MOVI also indirect. Next beat is taken once in idle, even
// while the last result waits on the output register. Configuration is always ready.
module stack_machine_bytecode_core
  import smbc_pkg::*;
#(
  parameter int PROG_DEPTH  = 4096,
  parameter int STACK_DEPTH = 1024,
  parameter int CALL_DEPTH  = 64,
  parameter int WORD_WIDTH  = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  smbc_in_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output smbc_out_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [12:0] cfg_data
);

  localparam int PA  = $clog2(PROG_DEPTH);
  localparam int PCW = PA + 1;
  localparam int SA  = $clog2(STACK_DEPTH);
  localparam int SCW = SA + 1;
  localparam int FA  = $clog2(CALL_DEPTH);
  localparam int FCW = FA + 1;
  localparam int XW  = WORD_WIDTH + 1;
  localparam int TW  = ((WORD_WIDTH > PCW) ? WORD_WIDTH : PCW) + 1;
  localparam int FRW = SA + PA;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_FETCH = 4'd1;
  localparam logic [3:0] S_OPND1 = 4'd2;
  localparam logic [3:0] S_OPND2 = 4'd3;
  localparam logic [3:0] S_TOP   = 4'd4;
  localparam logic [3:0] S_SEC   = 4'd5;
  localparam logic [3:0] S_IND   = 4'd6;
  localparam logic [3:0] S_FRAME = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  logic [3:0]            state_r, state_nxt;
  logic [PCW-1:0]        pc_r, pc_nxt;
  logic                  halt_r, halt_nxt;
  logic [SCW-1:0]        cnt_r, cnt_nxt;
  logic [FCW-1:0]        fcnt_r, fcnt_nxt;
  logic [SA-1:0]         off_r, off_nxt;
  logic [PA-1:0]         org_r, org_nxt;
  logic [PCW-1:0]        eff_len_r, eff_len_nxt;
  logic [4:0]            opk_r, opk_nxt;
  logic [WORD_WIDTH-1:0] op_r, op_nxt;
  logic [WORD_WIDTH-1:0] a_r, a_nxt;
  logic [WORD_WIDTH-1:0] b_r, b_nxt;
  logic [WORD_WIDTH-1:0] scan_r, scan_nxt;
  logic [WORD_WIDTH-1:0] pval_r, pval_nxt;
  logic [2:0]            fault_r, fault_nxt;
  logic                  pv_r, pv_nxt;
  logic                  st_r, st_nxt;
  logic                  out_valid_r, out_valid_nxt;
  smbc_out_t             out_r, out_nxt;

  logic                  pm_en, pm_we;
  logic [PA-1:0]         pm_addr;
  logic [WORD_WIDTH-1:0] pm_wdata, pm_rdata;
  logic                  ds_en, ds_we;
  logic [SA-1:0]         ds_addr;
  logic [WORD_WIDTH-1:0] ds_wdata, ds_rdata;
  logic                  fm_en, fm_we;
  logic [FA-1:0]         fm_addr;
  logic [FRW-1:0]        fm_wdata, fm_rdata;

  logic                  goto_en;
  logic [TW-1:0]         goto_tgt;
  logic [TW-1:0]         pc1, pc2, eff_t;
  logic [4:0]            opk_rd;
  logic [XW-1:0]         call_off;
  logic [WORD_WIDTH-1:0] alu_res;

  function automatic logic idx_ok(input logic [WORD_WIDTH-1:0] x, input logic [SA-1:0] off,
                                  input logic [SCW-1:0] cnt);
    logic [XW-1:0] xe;
    logic [XW-1:0] s;
    xe = XW'(x);
    s  = XW'(off) + xe;
    return (xe < XW'(cnt)) && (s < XW'(cnt));
  endfunction

  smbc_ram #(.WIDTH(WORD_WIDTH), .DEPTH(PROG_DEPTH)) u_prog (
    .clk(clk), .en(pm_en), .we(pm_we), .addr(pm_addr), .wdata(pm_wdata), .rdata(pm_rdata)
  );

  smbc_ram #(.WIDTH(WORD_WIDTH), .DEPTH(STACK_DEPTH)) u_stack (
    .clk(clk), .en(ds_en), .we(ds_we), .addr(ds_addr), .wdata(ds_wdata), .rdata(ds_rdata)
  );

  smbc_ram #(.WIDTH(FRW), .DEPTH(CALL_DEPTH)) u_frame (
    .clk(clk), .en(fm_en), .we(fm_we), .addr(fm_addr), .wdata(fm_wdata), .rdata(fm_rdata)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign pc1      = TW'(pc_r) + TW'(1);
  assign pc2      = TW'(pc_r) + TW'(2);
  assign eff_t    = TW'(eff_len_r);
  assign opk_rd   = (pm_rdata <= WORD_WIDTH'(OP_STOP)) ? pm_rdata[4:0] : OP_UNKNOWN;
  assign call_off = XW'(op_r) + XW'(off_r);

  always_comb begin
    case (opk_r)
      OP_ADD:  alu_res = a_r + ds_rdata;
      OP_SUB:  alu_res = a_r - ds_rdata;
      OP_LESS: alu_res = WORD_WIDTH'($signed(a_r) < $signed(ds_rdata));
      OP_EQU:  alu_res = WORD_WIDTH'(a_r == ds_rdata);
      OP_GRT:  alu_res = WORD_WIDTH'($signed(ds_rdata) < $signed(a_r));
      default: alu_res = '0;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    pc_nxt        = pc_r;
    halt_nxt      = halt_r;
    cnt_nxt       = cnt_r;
    fcnt_nxt      = fcnt_r;
    off_nxt       = off_r;
    org_nxt       = org_r;
    eff_len_nxt   = eff_len_r;
    opk_nxt       = opk_r;
    op_nxt        = op_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    scan_nxt      = scan_r;
    pval_nxt      = pval_r;
    fault_nxt     = fault_r;
    pv_nxt        = pv_r;
    st_nxt        = st_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    pm_en         = 1'b0;
    pm_we         = 1'b0;
    pm_addr       = pc_r[PA-1:0];
    pm_wdata      = WORD_WIDTH'(in_data.data);
    ds_en         = 1'b0;
    ds_we         = 1'b0;
    ds_addr       = '0;
    ds_wdata      = '0;
    fm_en         = 1'b0;
    fm_we         = 1'b0;
    fm_addr       = '0;
    fm_wdata      = {off_r, org_r};
    goto_en       = 1'b0;
    goto_tgt      = '0;

    if (cfg_valid) begin
      if (32'(cfg_data) >= 32'(PROG_DEPTH)) begin
        eff_len_nxt = PCW'(PROG_DEPTH);
      end else begin
        eff_len_nxt = PCW'(cfg_data);
      end
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          pv_nxt    = 1'b0;
          st_nxt    = 1'b0;
          pval_nxt  = '0;
          fault_nxt = FLT_NONE;
          scan_nxt  = WORD_WIDTH'(in_data.scan_value);
          state_nxt = S_DONE;
          case (in_data.cmd)
            CMD_LOAD: begin
              pm_en   = 1'b1;
              pm_we   = 1'b1;
              pm_addr = PA'(in_data.address);
            end
            CMD_RESTART: begin
              pc_nxt   = '0;
              halt_nxt = 1'b0;
              cnt_nxt  = '0;
              fcnt_nxt = FCW'(1);
              off_nxt  = '0;
              org_nxt  = '0;
            end
            CMD_STEP: begin
              if (!halt_r) begin
                if (pc_r >= eff_len_r) begin
                  goto_en  = 1'b1;
                  goto_tgt = TW'(pc_r);
                end else begin
                  pm_en     = 1'b1;
                  state_nxt = S_FETCH;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_FETCH: begin
        opk_nxt   = opk_rd;
        state_nxt = S_DONE;
        case (opk_rd)
          OP_PUSH, OP_LOAD, OP_JMP, OP_JMZ, OP_CALL: begin
            if (pc1 >= eff_t) begin
              fault_nxt = FLT_BAD_INDEX;
              halt_nxt  = 1'b1;
            end else begin
              pm_en     = 1'b1;
              pm_addr   = PA'(pc1);
              state_nxt = S_OPND1;
            end
          end
          OP_POP: begin
            if (cnt_r == '0) begin
              fault_nxt = FLT_UNDERFLOW;
              halt_nxt  = 1'b1;
            end else begin
              cnt_nxt  = cnt_r - SCW'(1);
              goto_en  = 1'b1;
              goto_tgt = pc1;
            end
          end
          OP_MOVI, OP_ADD, OP_SUB, OP_LESS, OP_EQU, OP_GRT: begin
            if (cnt_r < SCW'(2)) begin
              fault_nxt = FLT_UNDERFLOW;
              halt_nxt  = 1'b1;
            end else begin
              ds_en     = 1'b1;
              ds_addr   = SA'(cnt_r - SCW'(1));
              state_nxt = S_TOP;
            end
          end
          OP_PRINTI, OP_SCANI: begin
            if (cnt_r == '0) begin
              fault_nxt = FLT_UNDERFLOW;
              halt_nxt  = 1'b1;
            end else begin
              ds_en     = 1'b1;
              ds_addr   = SA'(cnt_r - SCW'(1));
              state_nxt = S_TOP;
            end
          end
          OP_RET: begin
            if (fcnt_r <= FCW'(1)) begin
              fault_nxt = FLT_RET_BASE;
              halt_nxt  = 1'b1;
            end else begin
              fcnt_nxt  = fcnt_r - FCW'(1);
              goto_en   = 1'b1;
              goto_tgt  = TW'(org_r) + TW'(1);
              fm_en     = 1'b1;
              fm_addr   = FA'(fcnt_r - FCW'(2));
              state_nxt = S_FRAME;
            end
          end
          OP_STOP: begin
            halt_nxt = 1'b1;
          end
          default: begin
            goto_en  = 1'b1;
            goto_tgt = pc1;
          end
        endcase
      end

      S_OPND1: begin
        op_nxt    = pm_rdata;
        state_nxt = S_DONE;
        case (opk_r)
          OP_PUSH: begin
            if (cnt_r >= SCW'(STACK_DEPTH)) begin
              fault_nxt = FLT_OVERFLOW;
              halt_nxt  = 1'b1;
            end else begin
              ds_en    = 1'b1;
              ds_we    = 1'b1;
              ds_addr  = SA'(cnt_r);
              ds_wdata = pm_rdata;
              cnt_nxt  = cnt_r + SCW'(1);
              goto_en  = 1'b1;
              goto_tgt = pc2;
            end
          end
          OP_LOAD: begin
            if (!idx_ok(pm_rdata, off_r, cnt_r)) begin
              fault_nxt = FLT_BAD_INDEX;
              halt_nxt  = 1'b1;
            end else if (cnt_r >= SCW'(STACK_DEPTH)) begin
              fault_nxt = FLT_OVERFLOW;
              halt_nxt  = 1'b1;
            end else begin
              ds_en     = 1'b1;
              ds_addr   = SA'(XW'(off_r) + XW'(pm_rdata));
              state_nxt = S_IND;
            end
          end
          OP_JMP: begin
            goto_en  = 1'b1;
            goto_tgt = TW'(pm_rdata);
          end
          OP_JMZ: begin
            if (cnt_r == '0) begin
              fault_nxt = FLT_UNDERFLOW;
              halt_nxt  = 1'b1;
            end else begin
              ds_en     = 1'b1;
              ds_addr   = SA'(cnt_r - SCW'(1));
              state_nxt = S_TOP;
            end
          end
          default: begin
            if (pc2 >= eff_t) begin
              fault_nxt = FLT_BAD_INDEX;
              halt_nxt  = 1'b1;
            end else begin
              pm_en     = 1'b1;
              pm_addr   = PA'(pc2);
              state_nxt = S_OPND2;
            end
          end
        endcase
      end

      S_OPND2: begin
        state_nxt = S_DONE;
        if ((XW'(op_r) >= XW'(STACK_DEPTH)) || (call_off >= XW'(STACK_DEPTH))) begin
          fault_nxt = FLT_BAD_INDEX;
          halt_nxt  = 1'b1;
        end else if (fcnt_r >= FCW'(CALL_DEPTH)) begin
          fault_nxt = FLT_CALL_OVF;
          halt_nxt  = 1'b1;
        end else begin
          fm_en    = 1'b1;
          fm_we    = 1'b1;
          fm_addr  = FA'(fcnt_r - FCW'(1));
          off_nxt  = SA'(call_off);
          org_nxt  = PA'(pc2);
          fcnt_nxt = fcnt_r + FCW'(1);
          goto_en  = 1'b1;
          goto_tgt = TW'(pm_rdata);
        end
      end

      S_TOP: begin
        a_nxt     = ds_rdata;
        state_nxt = S_DONE;
        case (opk_r)
          OP_JMZ: begin
            cnt_nxt  = cnt_r - SCW'(1);
            goto_en  = 1'b1;
            goto_tgt = (ds_rdata == '0) ? TW'(op_r) : pc2;
          end
          OP_PRINTI: begin
            if (!idx_ok(ds_rdata, off_r, cnt_r)) begin
              fault_nxt = FLT_BAD_INDEX;
              halt_nxt  = 1'b1;
            end else begin
              ds_en     = 1'b1;
              ds_addr   = SA'(XW'(off_r) + XW'(ds_rdata));
              state_nxt = S_IND;
            end
          end
          OP_SCANI: begin
            if (!idx_ok(ds_rdata, off_r, cnt_r)) begin
              fault_nxt = FLT_BAD_INDEX;
              halt_nxt  = 1'b1;
            end else begin
              ds_en    = 1'b1;
              ds_we    = 1'b1;
              ds_addr  = SA'(XW'(off_r) + XW'(ds_rdata));
              ds_wdata = scan_r;
              st_nxt   = 1'b1;
              goto_en  = 1'b1;
              goto_tgt = pc1;
            end
          end
          default: begin
            ds_en     = 1'b1;
            ds_addr   = SA'(cnt_r - SCW'(2));
            state_nxt = S_SEC;
          end
        endcase
      end

      S_SEC: begin
        b_nxt     = ds_rdata;
        state_nxt = S_DONE;
        if (opk_r == OP_MOVI) begin
          if (!idx_ok(a_r, off_r, cnt_r) || !idx_ok(ds_rdata, off_r, cnt_r)) begin
            fault_nxt = FLT_BAD_INDEX;
            halt_nxt  = 1'b1;
          end else begin
            ds_en     = 1'b1;
            ds_addr   = SA'(XW'(off_r) + XW'(a_r));
            state_nxt = S_IND;
          end
        end else begin
          ds_en    = 1'b1;
          ds_we    = 1'b1;
          ds_addr  = SA'(cnt_r - SCW'(2));
          ds_wdata = alu_res;
          cnt_nxt  = cnt_r - SCW'(1);
          goto_en  = 1'b1;
          goto_tgt = pc1;
        end
      end

      S_IND: begin
        state_nxt = S_DONE;
        goto_en   = 1'b1;
        goto_tgt  = pc1;
        case (opk_r)
          OP_LOAD: begin
            ds_en    = 1'b1;
            ds_we    = 1'b1;
            ds_addr  = SA'(cnt_r);
            ds_wdata = ds_rdata;
            cnt_nxt  = cnt_r + SCW'(1);
            goto_tgt = pc2;
          end
          OP_PRINTI: begin
            pv_nxt   = 1'b1;
            pval_nxt = ds_rdata;
          end
          default: begin
            ds_en    = 1'b1;
            ds_we    = 1'b1;
            ds_addr  = SA'(XW'(off_r) + XW'(b_r));
            ds_wdata = ds_rdata;
          end
        endcase
      end

      S_FRAME: begin
        off_nxt   = fm_rdata[FRW-1:PA];
        org_nxt   = fm_rdata[PA-1:0];
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt       = 1'b1;
          out_nxt.pc          = 13'(pc_r);
          out_nxt.halted      = halt_r;
          out_nxt.print_valid = pv_r;
          out_nxt.print_value = 32'(pval_r);
          out_nxt.scan_taken  = st_r;
          out_nxt.fault       = fault_r;
          state_nxt           = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (goto_en) begin
      if (goto_tgt >= eff_t) begin
        pc_nxt   = eff_len_r;
        halt_nxt = 1'b1;
      end else begin
        pc_nxt = PCW'(goto_tgt);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pc_r        <= '0;
      halt_r      <= 1'b0;
      cnt_r       <= '0;
      fcnt_r      <= FCW'(1);
      off_r       <= '0;
      org_r       <= '0;
      eff_len_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pc_r        <= pc_nxt;
      halt_r      <= halt_nxt;
      cnt_r       <= cnt_nxt;
      fcnt_r      <= fcnt_nxt;
      off_r       <= off_nxt;
      org_r       <= org_nxt;
      eff_len_r   <= eff_len_nxt;
      out_valid_r <= out_valid_nxt;
    end
    opk_r   <= opk_nxt;
    op_r    <= op_nxt;
    a_r     <= a_nxt;
    b_r     <= b_nxt;
    scan_r  <= scan_nxt;
    pval_r  <= pval_nxt;
    fault_r <= fault_nxt;
    pv_r    <= pv_nxt;
    st_r    <= st_nxt;
    out_r   <= out_nxt;
  end

  a_fault_halts: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.fault != FLT_NONE)) |-> out_data.halted)
    else $error("fault reported without halt");

  a_one_side_effect: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.print_valid && out_data.scan_taken))
    else $error("print and scan in the same beat");

  a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cnt_r) <= 32'(STACK_DEPTH))
    else $error("data stack count beyond depth");

  a_frame_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (fcnt_r != '0) && (32'(fcnt_r) <= 32'(CALL_DEPTH)))
    else $error("frame count out of range");

endmodule

FILE: rtl/smbc_ram.sv
// Generic single-port synchronous RAM with a registered read port.
// No dependencies.
module smbc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule
